@@ src/grtt_pkg.sv @@
package grtt_pkg;

  // Operation codes carried in the request opcode field.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_XLATE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Response status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD     = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISS    = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FLUSH = 2'd2,
    S_RESP  = 2'd3
  } state_e;

  localparam int AddrW    = 64;
  localparam int LimitW   = 5;
  localparam int SlotOutW = 4;
  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch the request and start a new item
    logic clear;    // free every slot
    logic rd_en;    // read the next slot of the scan
    logic respond;  // build the response and commit an add
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_rd;  // the current read is the last slot
    logic out_free; // the output register can take a response
  } dp_sts_t;

endpackage

@@ src/grtt_req_if.sv @@
interface grtt_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     opcode;
  logic [grtt_pkg::AddrW-1:0]     guest_addr;
  logic [grtt_pkg::AddrW-1:0]     region_size;
  logic [grtt_pkg::AddrW-1:0]     host_base;

  modport source (output valid, opcode, guest_addr, region_size, host_base, input ready);
  modport sink (input valid, opcode, guest_addr, region_size, host_base, output ready);
endinterface

@@ src/grtt_rsp_if.sv @@
interface grtt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        status;
  logic [grtt_pkg::AddrW-1:0]        host_addr;
  logic [grtt_pkg::SlotOutW-1:0]     slot_index;

  modport source (output valid, status, host_addr, slot_index, input ready);
  modport sink (input valid, status, host_addr, slot_index, output ready);
endinterface

@@ src/guest_region_translation_table_unit.sv @@
// Add and translate scan every slot in turn, then pass through a flush state
// for the last RAM read and answer from the response state; clear and the
// unused opcode go straight to the response state.
// Only one request is handled at a time, and an answer waits while the output
// register is full; the one-read-port region RAM is scanned a slot per cycle.
// Reset: all slots free, slot limit 16; no clearing pass is needed.
module guest_region_translation_table_unit #(
  parameter int Slots = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  grtt_req_if.sink                      req_i,
  grtt_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [grtt_pkg::LimitW-1:0]   cfg_wdata_i
);

  grtt_pkg::dp_cmd_t cmd;
  grtt_pkg::dp_sts_t sts;

  // Sequencer.
  grtt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Region table, scan checks and response register.
  grtt_dpath #(
    .Slots (Slots)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (req_i.opcode),
    .guest_addr_i     (req_i.guest_addr),
    .region_size_i    (req_i.region_size),
    .host_base_i      (req_i.host_base),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_status_o     (rsp_o.status),
    .rsp_host_addr_o  (rsp_o.host_addr),
    .rsp_slot_index_o (rsp_o.slot_index)
  );

endmodule

@@ src/grtt_ram.sv @@
module grtt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/grtt_ctrl.sv @@
module grtt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [1:0]        req_opcode_i,
  output logic              req_ready_o,
  input  grtt_pkg::dp_sts_t sts_i,
  output grtt_pkg::dp_cmd_t cmd_o
);

  grtt_pkg::state_e state_q, state_d;
  grtt_pkg::op_e    op;
  logic             accept;
  logic             is_scan_op;

  assign op         = grtt_pkg::op_e'(req_opcode_i);
  assign accept     = (state_q == grtt_pkg::S_IDLE) && req_valid_i;
  assign is_scan_op = (op == grtt_pkg::OP_ADD) || (op == grtt_pkg::OP_XLATE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grtt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: adds and translates scan every slot, the rest go straight to the response state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      grtt_pkg::S_IDLE: begin
        if (accept) begin
          state_d = is_scan_op ? grtt_pkg::S_SCAN : grtt_pkg::S_RESP;
        end
      end
      grtt_pkg::S_SCAN: begin
        if (sts_i.last_rd) begin
          state_d = grtt_pkg::S_FLUSH;
        end
      end
      grtt_pkg::S_FLUSH: begin
        state_d = grtt_pkg::S_RESP;
      end
      grtt_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          state_d = grtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = grtt_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      grtt_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = accept;
        cmd_o.clear = accept && (op == grtt_pkg::OP_CLEAR);
      end
      grtt_pkg::S_SCAN: begin
        cmd_o.rd_en = 1'b1;
      end
      grtt_pkg::S_FLUSH: begin
        cmd_o = '0;
      end
      grtt_pkg::S_RESP: begin
        cmd_o.respond = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ src/grtt_dpath.sv @@
module grtt_dpath #(
  parameter int Slots = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grtt_pkg::dp_cmd_t                   cmd_i,
  output grtt_pkg::dp_sts_t                   sts_o,
  input  logic [1:0]                          opcode_i,
  input  logic [grtt_pkg::AddrW-1:0]          guest_addr_i,
  input  logic [grtt_pkg::AddrW-1:0]          region_size_i,
  input  logic [grtt_pkg::AddrW-1:0]          host_base_i,
  input  logic                                cfg_we_i,
  input  logic [grtt_pkg::LimitW-1:0]         cfg_wdata_i,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  output logic [2:0]                          rsp_status_o,
  output logic [grtt_pkg::AddrW-1:0]          rsp_host_addr_o,
  output logic [grtt_pkg::SlotOutW-1:0]       rsp_slot_index_o
);

  localparam int IdxW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int CmpW  = (IdxW + 1 > grtt_pkg::LimitW) ? IdxW + 1 : grtt_pkg::LimitW;
  localparam int AW    = grtt_pkg::AddrW;
  localparam int EntW  = 3 * AW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Slots - 1);

  // Request registers.
  grtt_pkg::op_e          op_q;
  logic [AW-1:0]          addr_q, size_q, hbase_q, end_q;
  logic                   bad_q;
  logic [AW:0]            end_sum;

  // Slot state.
  logic [grtt_pkg::LimitW-1:0] limit_q;
  logic [Slots-1:0]       used_q;

  // Scan pipeline.
  logic [IdxW-1:0]        idx_q, rd_idx_q;
  logic                   rd_vld_q, rd_used_q;
  logic [EntW-1:0]        rd_data;
  logic [AW-1:0]          ent_start, ent_len, ent_host;
  logic [AW:0]            diff;
  logic [AW-1:0]          ent_end;
  logic                   eval, hit, ovl, free_cand;

  // Scan results.
  logic                   hit_q, ovl_q, free_q;
  logic [IdxW-1:0]        match_idx_q, free_idx_q;
  logic [AW-1:0]          diff_q, mhost_q;

  // Output register.
  logic                   rsp_vld_q;
  grtt_pkg::status_e      status_q;
  logic [AW-1:0]          host_q;
  logic [IdxW-1:0]        slot_q;
  logic [IdxW+grtt_pkg::SlotOutW-1:0] slot_ext;

  logic                   add_ok, wr_en;
  grtt_pkg::status_e      status_d;

  assign end_sum = {1'b0, guest_addr_i} + {1'b0, region_size_i};

  // Latch the request; a zero size or a range past the top is rejected.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= grtt_pkg::op_e'(opcode_i);
      addr_q  <= guest_addr_i;
      size_q  <= region_size_i;
      hbase_q <= host_base_i;
      end_q   <= end_sum[AW-1:0];
      bad_q   <= (region_size_i == '0) || end_sum[AW];
    end
  end

  // Slot limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= grtt_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Region table: start, length and host base of each slot.
  grtt_ram #(
    .Width (EntW),
    .Depth (Slots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (free_idx_q),
    .wdata_i ({addr_q, size_q, hbase_q}),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign {ent_start, ent_len, ent_host} = rd_data;

  // Scan counter and read pipeline; the used bit is registered with the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_used_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.rd_en) begin
        idx_q     <= idx_q + 1'b1;
        rd_used_q <= used_q[idx_q];
        rd_idx_q  <= idx_q;
      end
    end
  end

  assign sts_o.last_rd  = cmd_i.rd_en && (idx_q == LastIdx);
  assign sts_o.out_free = !rsp_vld_q || rsp_ready_i;

  // Per-slot checks: containment for translate, overlap and free slot for add.
  assign eval      = rd_vld_q && rd_used_q;
  assign diff      = {1'b0, addr_q} - {1'b0, ent_start};
  assign hit       = eval && !diff[AW] && (diff[AW-1:0] < ent_len);
  assign ent_end   = ent_start + ent_len;
  assign ovl       = eval && (end_q > ent_start) && (ent_end > addr_q);
  assign free_cand = rd_vld_q && !rd_used_q && (CmpW'(rd_idx_q) < CmpW'(limit_q));

  // Keep the lowest matching slot and the lowest free slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      ovl_q       <= 1'b0;
      free_q      <= 1'b0;
      match_idx_q <= '0;
      free_idx_q  <= '0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      ovl_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (hit && !hit_q) begin
        hit_q       <= 1'b1;
        match_idx_q <= rd_idx_q;
      end
      if (ovl) begin
        ovl_q <= 1'b1;
      end
      if (free_cand && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // Offset and host base of the matched slot.
  always_ff @(posedge clk_i) begin
    if (hit && !hit_q) begin
      diff_q  <= diff[AW-1:0];
      mhost_q <= ent_host;
    end
  end

  assign add_ok = !bad_q && !ovl_q && free_q;
  assign wr_en  = cmd_i.respond && (op_q == grtt_pkg::OP_ADD) && add_ok;

  // Used bits: cleared all at once, set when an add commits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.clear) begin
      used_q <= '0;
    end else if (wr_en) begin
      used_q[free_idx_q] <= 1'b1;
    end
  end

  // Response status.
  always_comb begin
    status_d = grtt_pkg::ST_OK;
    case (op_q)
      grtt_pkg::OP_ADD: begin
        if (bad_q) begin
          status_d = grtt_pkg::ST_BAD;
        end else if (ovl_q) begin
          status_d = grtt_pkg::ST_OVERLAP;
        end else if (!free_q) begin
          status_d = grtt_pkg::ST_FULL;
        end
      end
      grtt_pkg::OP_XLATE: begin
        if (!hit_q) begin
          status_d = grtt_pkg::ST_MISS;
        end
      end
      default: begin
        status_d = grtt_pkg::ST_OK;
      end
    endcase
  end

  // Output register; the valid flag drops after the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (cmd_i.respond) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      status_q <= status_d;
      host_q   <= '0;
      slot_q   <= '0;
      if ((op_q == grtt_pkg::OP_XLATE) && hit_q) begin
        host_q <= diff_q + mhost_q;
        slot_q <= match_idx_q;
      end else if (wr_en) begin
        slot_q <= free_idx_q;
      end
    end
  end

  assign slot_ext         = {{grtt_pkg::SlotOutW{1'b0}}, slot_q};
  assign rsp_valid_o      = rsp_vld_q;
  assign rsp_status_o     = status_q;
  assign rsp_host_addr_o  = host_q;
  assign rsp_slot_index_o = slot_ext[grtt_pkg::SlotOutW-1:0];

endmodule

@@ src/grtt_checker.sv @@
module grtt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic [2:0]                       rsp_status_i,
  input logic [grtt_pkg::AddrW-1:0]       rsp_host_addr_i,
  input logic [grtt_pkg::SlotOutW-1:0]    rsp_slot_index_i
);

  // A response that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before its transfer");

  // Only one request is in flight: ready drops right after a transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in progress");

  // A failed operation returns no address and no slot.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != grtt_pkg::ST_OK)
      |-> (rsp_host_addr_i == '0) && (rsp_slot_index_i == '0))
    else $error("failed response carries address or slot");

endmodule

bind guest_region_translation_table_unit grtt_checker u_grtt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_host_addr_i  (rsp_o.host_addr),
  .rsp_slot_index_i (rsp_o.slot_index)
);
